### rtl/core/wha_pkg.sv
// ----------------------------------------------------------------------------
// wha_pkg
// Shared widths and codes for the weighted histogram accumulator.
// ----------------------------------------------------------------------------
package wha_pkg;

  localparam int unsigned ValW = 32;  // Q16.16 sample value and minimum
  localparam int unsigned WgtW = 32;  // Q16.16 weight
  localparam int unsigned VolW = 48;  // Q32.16 bin volume
  localparam int unsigned CmpW = 2;   // component field
  localparam int unsigned RbnW = 6;   // read bin field
  localparam int unsigned NbW  = 7;   // bins in use register
  localparam int unsigned NcW  = 3;   // components in use register
  localparam int unsigned CfgAW = 2;  // config register index
  localparam int unsigned CfgDW = 32; // config write data

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [CfgAW-1:0] {
    CFG_MIN_VALUE     = 2'd0,
    CFG_BINS_PER_UNIT = 2'd1,
    CFG_BINS_IN_USE   = 2'd2,
    CFG_COMPS_IN_USE  = 2'd3
  } cfg_idx_e;

  localparam logic [ValW-1:0] MinValueRst    = 32'sd0;
  localparam logic [ValW-1:0] BinsPerUnitRst = 32'd65536;
  localparam logic [NbW-1:0]  BinsInUseRst   = 7'd50;
  localparam logic [NcW-1:0]  CompsInUseRst  = 3'd1;

  localparam logic [VolW-1:0] VolMax = {VolW{1'b1}};

endpackage

### rtl/core/weighted_histogram_accumulator_top.sv
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator_top
// Per-component weighted histogram with saturating Q32.16 bins.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: an item is taken on a rising edge with start_i high and
//    busy_o low. busy_o is held low, so one item can be issued every cycle.
//  - kind_i: add sample, read bin, or clear all bins. Only a read returns a
//    result, shown for one cycle with bin_valid_o high; the receiver cannot
//    stall it and must take it in that cycle.
//  - Flow: a read result passes P1 to P4, then the result register. Adds
//    and clears are done in the same slot, so items in any mix run at one
//    item per cycle, set by the single bin RAM read-modify-write slot with
//    forwarding from the update stage.
//  - Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i/cfg_data_i;
//    ready is always high. Write only while no item is in flight.
//  - Reset: registers go to their defaults and every bin reads as zero at
//    once (one valid bit per bin, cleared by reset or a clear item). No
//    clearing pass is needed.
// Pipeline: P1 input reg, P2 |value - min|, P3 bin = (mag * bins_per_unit)
// >> 32, P4 bin RAM data + saturating add, then the result register.
// ----------------------------------------------------------------------------
module weighted_histogram_accumulator_top #(
  parameter int unsigned MAX_BINS       = 64,
  parameter int unsigned MAX_COMPONENTS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          kind_i,
  input  logic [wha_pkg::CmpW-1:0]            component_i,
  input  logic signed [wha_pkg::ValW-1:0]     sample_value_i,
  input  logic [wha_pkg::WgtW-1:0]            weight_i,
  input  logic [wha_pkg::RbnW-1:0]            read_bin_i,
  // result
  output logic                                bin_valid_o,
  output logic [wha_pkg::VolW-1:0]            bin_volume_o,
  output logic [wha_pkg::CmpW-1:0]            bin_component_o,
  output logic [wha_pkg::RbnW-1:0]            bin_index_o,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wha_pkg::CfgAW-1:0]           cfg_index_i,
  input  logic [wha_pkg::CfgDW-1:0]           cfg_data_i
);

  localparam int unsigned Depth = MAX_BINS * MAX_COMPONENTS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ValW  = wha_pkg::ValW;
  localparam int unsigned VolW  = wha_pkg::VolW;

  // never stalls
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic accept;
  assign accept = start_i & ~busy_o;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [ValW-1:0]          min_value_q;
  logic [ValW-1:0]          bins_per_unit_q;
  logic [wha_pkg::NbW-1:0]  bins_in_use_q;
  logic [wha_pkg::NcW-1:0]  comps_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q     <= wha_pkg::MinValueRst;
      bins_per_unit_q <= wha_pkg::BinsPerUnitRst;
      bins_in_use_q   <= wha_pkg::BinsInUseRst;
      comps_in_use_q  <= wha_pkg::CompsInUseRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (wha_pkg::cfg_idx_e'(cfg_index_i))
        wha_pkg::CFG_MIN_VALUE:     min_value_q     <= cfg_data_i;
        wha_pkg::CFG_BINS_PER_UNIT: bins_per_unit_q <= cfg_data_i;
        wha_pkg::CFG_BINS_IN_USE:   bins_in_use_q   <= cfg_data_i[wha_pkg::NbW-1:0];
        wha_pkg::CFG_COMPS_IN_USE:  comps_in_use_q  <= cfg_data_i[wha_pkg::NcW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // P1: input register
  // --------------------------------------------------------------------------
  logic                     p1_vld_q;
  logic [1:0]               p1_kind_q;
  logic [wha_pkg::CmpW-1:0] p1_comp_q;
  logic [ValW-1:0]          p1_val_q;
  logic [wha_pkg::WgtW-1:0] p1_wgt_q;
  logic [wha_pkg::RbnW-1:0] p1_rbin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_kind_q <= kind_i;
      p1_comp_q <= component_i;
      p1_val_q  <= sample_value_i;
      p1_wgt_q  <= weight_i;
      p1_rbin_q <= read_bin_i;
    end
  end

  // --------------------------------------------------------------------------
  // P2: magnitude and sign of value - min (exact in 33 bits, |diff| < 2^32)
  // --------------------------------------------------------------------------
  logic [ValW:0]   diff_pos, diff_neg;
  logic            diff_is_neg;
  logic [ValW-1:0] mag_d;

  assign diff_pos    = {p1_val_q[ValW-1], p1_val_q} - {min_value_q[ValW-1], min_value_q};
  assign diff_neg    = {min_value_q[ValW-1], min_value_q} - {p1_val_q[ValW-1], p1_val_q};
  assign diff_is_neg = diff_pos[ValW];
  assign mag_d       = diff_is_neg ? diff_neg[ValW-1:0] : diff_pos[ValW-1:0];

  logic                     p2_vld_q;
  logic [1:0]               p2_kind_q;
  logic [wha_pkg::CmpW-1:0] p2_comp_q;
  logic [ValW-1:0]          p2_mag_q;
  logic                     p2_neg_q;
  logic [wha_pkg::WgtW-1:0] p2_wgt_q;
  logic [wha_pkg::RbnW-1:0] p2_rbin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_kind_q <= p1_kind_q;
    p2_comp_q <= p1_comp_q;
    p2_mag_q  <= mag_d;
    p2_neg_q  <= diff_is_neg;
    p2_wgt_q  <= p1_wgt_q;
    p2_rbin_q <= p1_rbin_q;
  end

  // --------------------------------------------------------------------------
  // P3: bin magnitude = integer part of Q32.32 product
  // --------------------------------------------------------------------------
  logic [2*ValW-1:0] prod;
  assign prod = {{ValW{1'b0}}, p2_mag_q} * {{ValW{1'b0}}, bins_per_unit_q};

  logic                     p3_vld_q;
  logic [1:0]               p3_kind_q;
  logic [wha_pkg::CmpW-1:0] p3_comp_q;
  logic [ValW-1:0]          p3_bin_q;
  logic                     p3_neg_q;
  logic [wha_pkg::WgtW-1:0] p3_wgt_q;
  logic [wha_pkg::RbnW-1:0] p3_rbin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_kind_q <= p2_kind_q;
    p3_comp_q <= p2_comp_q;
    p3_bin_q  <= prod[2*ValW-1:ValW];
    p3_neg_q  <= p2_neg_q;
    p3_wgt_q  <= p2_wgt_q;
    p3_rbin_q <= p2_rbin_q;
  end

  // range checks against the effective counts min(reg, MAX)
  logic comp_ok, smp_bin_ok, rd_bin_ok, smp_hit, rd_ok;
  logic [AW-1:0] bin_sel, raddr;

  assign comp_ok    = ({1'b0, p3_comp_q} < comps_in_use_q)
                    && (32'(p3_comp_q) < 32'(MAX_COMPONENTS));
  assign smp_bin_ok = (p3_bin_q < 32'(bins_in_use_q)) && (p3_bin_q < 32'(MAX_BINS))
                    && !(p3_neg_q && (p3_bin_q != '0));
  assign rd_bin_ok  = ({1'b0, p3_rbin_q} < bins_in_use_q)
                    && (32'(p3_rbin_q) < 32'(MAX_BINS));

  assign smp_hit = p3_vld_q && (p3_kind_q == wha_pkg::KIND_ADD) && comp_ok && smp_bin_ok;
  assign rd_ok   = comp_ok && rd_bin_ok;

  always_comb begin
    bin_sel = (p3_kind_q == wha_pkg::KIND_ADD) ? AW'(p3_bin_q) : AW'(p3_rbin_q);
    if (comp_ok && (smp_bin_ok || rd_bin_ok)) begin
      raddr = AW'(AW'(p3_comp_q) * AW'(MAX_BINS)) + bin_sel;
    end else begin
      raddr = '0;
    end
  end

  // --------------------------------------------------------------------------
  // P4: bin data, saturating add, write back
  // --------------------------------------------------------------------------
  logic                     p4_vld_q;
  logic [1:0]               p4_kind_q;
  logic [wha_pkg::CmpW-1:0] p4_comp_q;
  logic [wha_pkg::WgtW-1:0] p4_wgt_q;
  logic [wha_pkg::RbnW-1:0] p4_rbin_q;
  logic                     p4_wr_q;
  logic                     p4_rd_ok_q;
  logic [AW-1:0]            p4_addr_q;

  logic                     p4_clear;
  logic [VolW-1:0]          rdata_q;
  logic                     fwd_q;
  logic [VolW-1:0]          fwd_data_q;
  logic                     rd_zero_q;
  logic [Depth-1:0]         bin_vld_q;
  logic [VolW-1:0]          bin_mem [Depth];

  logic [VolW-1:0] old_vol;
  logic [VolW:0]   sum;
  logic [VolW-1:0] sum_sat;

  assign p4_clear = p4_vld_q && (p4_kind_q == wha_pkg::KIND_CLEAR);

  // older item in P4 takes priority: its write is forwarded, its clear zeroes
  always_comb begin
    if (fwd_q) begin
      old_vol = fwd_data_q;
    end else if (rd_zero_q) begin
      old_vol = '0;
    end else begin
      old_vol = rdata_q;
    end
  end

  assign sum     = {1'b0, old_vol} + (VolW+1)'(p4_wgt_q);
  assign sum_sat = sum[VolW] ? wha_pkg::VolMax : sum[VolW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q  <= 1'b0;
      p4_wr_q   <= 1'b0;
      fwd_q     <= 1'b0;
      rd_zero_q <= 1'b1;
      bin_vld_q <= '0;
    end else begin
      p4_vld_q  <= p3_vld_q;
      p4_wr_q   <= smp_hit;
      fwd_q     <= p4_wr_q && (p4_addr_q == raddr);
      rd_zero_q <= p4_clear || !bin_vld_q[raddr];
      if (p4_clear) begin
        bin_vld_q <= '0;
      end else if (p4_wr_q) begin
        bin_vld_q[p4_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p4_kind_q  <= p3_kind_q;
    p4_comp_q  <= p3_comp_q;
    p4_wgt_q   <= p3_wgt_q;
    p4_rbin_q  <= p3_rbin_q;
    p4_rd_ok_q <= rd_ok;
    p4_addr_q  <= raddr;
    fwd_data_q <= sum_sat;
  end

  // bin RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (p4_wr_q) begin
      bin_mem[p4_addr_q] <= sum_sat;
    end
    rdata_q <= bin_mem[raddr];
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_o <= 1'b0;
    end else begin
      bin_valid_o <= p4_vld_q && (p4_kind_q == wha_pkg::KIND_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_volume_o    <= p4_rd_ok_q ? old_vol : '0;
    bin_component_o <= p4_comp_q;
    bin_index_o     <= p4_rbin_q;
  end

endmodule

### tb/sv/histogram_checker.sv
// ----------------------------------------------------------------------------
// histogram_checker
// Watches the command, result and register channels of the weighted histogram
// accumulator, keeps its own copy of every bin and compares each bin read.
// ----------------------------------------------------------------------------
module histogram_checker #(
  parameter int unsigned MAX_BINS       = 64,
  parameter int unsigned MAX_COMPONENTS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [1:0]                    kind_i,
  input  logic [wha_pkg::CmpW-1:0]      component_i,
  input  logic [wha_pkg::ValW-1:0]      sample_value_i,
  input  logic [wha_pkg::WgtW-1:0]      weight_i,
  input  logic [wha_pkg::RbnW-1:0]      read_bin_i,
  input  logic                          bin_valid_i,
  input  logic [wha_pkg::VolW-1:0]      bin_volume_i,
  input  logic [wha_pkg::CmpW-1:0]      bin_component_i,
  input  logic [wha_pkg::RbnW-1:0]      bin_index_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [wha_pkg::CfgAW-1:0]     cfg_index_i,
  input  logic [wha_pkg::CfgDW-1:0]     cfg_data_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   reads_pending_o,
  output int unsigned                   items_seen_o,
  output int unsigned                   reads_checked_o
);
  import wha_pkg::*;

  localparam int unsigned BinCount  = MAX_BINS * MAX_COMPONENTS;

  typedef struct packed {
    logic [VolW-1:0] volume;
    logic [CmpW-1:0] comp;
    logic [RbnW-1:0] index;
  } bin_read_t;

  bin_read_t         awaited_reads[$];
  logic [VolW-1:0]   bin_store [BinCount];
  logic [ValW-1:0]   min_value_q;
  logic [31:0]       bins_per_unit_q;
  logic [NbW-1:0]    bins_in_use_q;
  logic [NcW-1:0]    comps_in_use_q;

  int unsigned       fails, items, reads;
  int unsigned       nb_eff, nc_eff, slot;
  longint            bin;
  logic [VolW:0]     sum;
  bin_read_t         got, want;

  // Bin of a sample under the current minimum and scale; -1 when the
  // difference is negative by at least one whole bin.
  function automatic longint bin_of_sample(input logic [ValW-1:0] value);
    logic signed [ValW:0] diff;
    logic [ValW:0]        mag;
    logic [63:0]          prod;
    diff = $signed({value[ValW-1], value}) - $signed({min_value_q[ValW-1], min_value_q});
    mag  = diff[ValW] ? $unsigned(-diff) : $unsigned(diff);
    prod = {31'b0, mag} * {32'b0, bins_per_unit_q};
    if (diff[ValW] && prod[63:32] != '0) return -1;
    return longint'(prod[63:32]);
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    fails++;
    $error("%s: expected %0h, got %0h", field, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_reads.delete();
      foreach (bin_store[i]) bin_store[i] = '0;
      min_value_q     = MinValueRst;
      bins_per_unit_q = BinsPerUnitRst;
      bins_in_use_q   = BinsInUseRst;
      comps_in_use_q  = CompsInUseRst;
      fails = 0;
      items = 0;
      reads = 0;
    end else begin
      if (bin_valid_i) begin
        got = '{bin_volume_i, bin_component_i, bin_index_i};
        if (awaited_reads.size() == 0) begin
          fails++;
          $error("bin read result with none outstanding: volume %0h", bin_volume_i);
        end else begin
          want = awaited_reads.pop_front();
          reads++;
          if (got.volume !== want.volume) note_mismatch("bin_volume", want.volume, got.volume);
          if (got.comp !== want.comp) note_mismatch("bin_component", want.comp, got.comp);
          if (got.index !== want.index) note_mismatch("bin_index", want.index, got.index);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_VALUE:     min_value_q     = cfg_data_i[ValW-1:0];
          CFG_BINS_PER_UNIT: bins_per_unit_q = cfg_data_i[31:0];
          CFG_BINS_IN_USE:   bins_in_use_q   = cfg_data_i[NbW-1:0];
          CFG_COMPS_IN_USE:  comps_in_use_q  = cfg_data_i[NcW-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        items++;
        nb_eff = (bins_in_use_q < MAX_BINS) ? bins_in_use_q : MAX_BINS;
        nc_eff = (comps_in_use_q < MAX_COMPONENTS) ? comps_in_use_q : MAX_COMPONENTS;
        case (kind_e'(kind_i))
          KIND_ADD: begin
            bin = bin_of_sample(sample_value_i);
            if (bin >= 0 && component_i < nc_eff && bin < longint'(nb_eff)) begin
              slot = component_i * MAX_BINS + int'(bin);
              sum  = {1'b0, bin_store[slot]} + {{(VolW+1-WgtW){1'b0}}, weight_i};
              bin_store[slot] = sum[VolW] ? VolMax : sum[VolW-1:0];
            end
          end
          KIND_READ: begin
            want = '{'0, component_i, read_bin_i};
            if (component_i < nc_eff && read_bin_i < nb_eff)
              want.volume = bin_store[component_i * MAX_BINS + read_bin_i];
            awaited_reads = {awaited_reads, want};
          end
          KIND_CLEAR: foreach (bin_store[i]) bin_store[i] = '0;
          default: ;  // unused kind: no effect
        endcase
      end
    end
  end

  // Published through nonblocking updates so the stimulus side reads a
  // settled value at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatches_o    <= 0;
      reads_pending_o <= 0;
      items_seen_o    <= 0;
      reads_checked_o <= 0;
    end else begin
      mismatches_o    <= fails;
      reads_pending_o <= awaited_reads.size();
      items_seen_o    <= items;
      reads_checked_o <= reads;
    end
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the weighted histogram accumulator: directed
// corner cases and randomised phases under varied settings.
// ----------------------------------------------------------------------------
module testbench;
  import wha_pkg::*;

  localparam int unsigned MaxBins  = 64;
  localparam int unsigned MaxComps = 4;
  localparam int unsigned Phases   = 8;
  localparam int unsigned PhaseLen = 75;
  localparam int unsigned Settle   = 6;   // read latency plus margin

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          kind_i;
  logic [CmpW-1:0]     component_i;
  logic [ValW-1:0]     sample_value_i;
  logic [WgtW-1:0]     weight_i;
  logic [RbnW-1:0]     read_bin_i;
  logic                bin_valid_o;
  logic [VolW-1:0]     bin_volume_o;
  logic [CmpW-1:0]     bin_component_o;
  logic [RbnW-1:0]     bin_index_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAW-1:0]    cfg_index_i;
  logic [CfgDW-1:0]    cfg_data_i;

  int unsigned         mismatches, reads_pending, items_seen, reads_checked;

  // Shadow of the register settings, used only to shape the stimulus so that
  // most samples land in bins that are in use.
  logic [31:0]         cur_min, cur_bpu;
  int unsigned         nb_eff, nc_eff, settings;

  weighted_histogram_accumulator_top #(
    .MAX_BINS       (MaxBins),
    .MAX_COMPONENTS (MaxComps)
  ) dut (
    .clk_i, .rst_ni,
    .start_i, .busy_o, .kind_i, .component_i, .sample_value_i, .weight_i, .read_bin_i,
    .bin_valid_o, .bin_volume_o, .bin_component_o, .bin_index_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  histogram_checker #(
    .MAX_BINS       (MaxBins),
    .MAX_COMPONENTS (MaxComps)
  ) bin_check (
    .clk_i, .rst_ni,
    .start_i, .busy_i (busy_o), .kind_i, .component_i, .sample_value_i, .weight_i,
    .read_bin_i,
    .bin_valid_i     (bin_valid_o),
    .bin_volume_i    (bin_volume_o),
    .bin_component_i (bin_component_o),
    .bin_index_i     (bin_index_o),
    .cfg_valid_i, .cfg_ready_i (cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatches_o    (mismatches),
    .reads_pending_o (reads_pending),
    .items_seen_o    (items_seen),
    .reads_checked_o (reads_checked)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog: ends the run as failed if it does not finish.
  initial begin
    #(20 * 600000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one item at the falling edge and hold it until it is taken.
  // start_i stays high so back-to-back items need no extra edge.
  task automatic send_item(input kind_e k, input logic [CmpW-1:0] c,
                           input logic [ValW-1:0] v, input logic [WgtW-1:0] w,
                           input logic [RbnW-1:0] rb);
    @(negedge clk_i);
    start_i        <= 1'b1;
    kind_i         <= k;
    component_i    <= c;
    sample_value_i <= v;
    weight_i       <= w;
    read_bin_i     <= rb;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Sender gap, its length given by n.
  task automatic hold_off(input int unsigned n);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop sending, wait for every outstanding read, then let the pipeline
  // empty of adds and clears before anything else happens.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (reads_pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CfgDW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // All four registers, written with the block idle.
  task automatic write_regs(input logic [31:0] mn, input logic [31:0] bpu,
                            input logic [31:0] nb, input logic [31:0] nc);
    drain();
    put_reg(CFG_MIN_VALUE, mn);
    put_reg(CFG_BINS_PER_UNIT, bpu);
    put_reg(CFG_BINS_IN_USE, nb);
    put_reg(CFG_COMPS_IN_USE, nc);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_min = mn;
    cur_bpu = bpu;
    nb_eff  = (32'(nb[NbW-1:0]) < MaxBins) ? 32'(nb[NbW-1:0]) : MaxBins;
    nc_eff  = (32'(nc[NcW-1:0]) < MaxComps) ? 32'(nc[NcW-1:0]) : MaxComps;
    settings++;
  endtask

  function automatic logic [WgtW-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return $urandom_range(0, 65536 * 4);
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CmpW-1:0] pick_comp();
    if (nc_eff != 0 && $urandom_range(0, 9) < 8) return CmpW'($urandom_range(0, nc_eff - 1));
    return CmpW'($urandom);
  endfunction

  // A sample aimed at a chosen bin: the bin width in Q16.16 is 2^32 over the
  // scale, so the offset from the minimum is bin * width plus a fraction.
  // Now and then the offset goes just below the minimum.
  task automatic send_aimed_sample();
    longint      width, frac, target, value;
    logic [63:0] raw;
    width  = (cur_bpu == 0) ? 65536 : ((longint'(1) << 32) / longint'(cur_bpu));
    frac   = longint'($urandom) % width;
    target = longint'($urandom_range(0, nb_eff)) * width + frac;
    if ($urandom_range(0, 9) == 0) target = -frac;
    value  = longint'($signed(cur_min)) + target;
    raw    = value;
    send_item(KIND_ADD, pick_comp(), raw[31:0], pick_weight(), RbnW'($urandom));
  endtask

  task automatic send_random_item();
    int unsigned roll;
    logic [RbnW-1:0] rb;
    roll = $urandom_range(1, 100);
    if (roll <= 55) begin
      send_aimed_sample();
    end else if (roll <= 65) begin
      send_item(KIND_ADD, CmpW'($urandom), $urandom, pick_weight(), RbnW'($urandom));
    end else if (roll <= 95) begin
      rb = RbnW'($urandom);
      if (nb_eff != 0 && $urandom_range(0, 9) < 8) rb = RbnW'($urandom_range(0, nb_eff - 1));
      send_item(KIND_READ, pick_comp(), $urandom, $urandom, rb);
    end else if (roll <= 97) begin
      send_item(KIND_CLEAR, CmpW'($urandom), $urandom, $urandom, RbnW'($urandom));
    end else begin
      send_item(KIND_NONE, CmpW'($urandom), $urandom, $urandom, RbnW'($urandom));
    end
  endtask

  // Random register setting for one phase; the bin and component registers
  // sometimes carry junk in their upper data bits.
  task automatic random_setting();
    logic [31:0] mn, bpu, nb, nc;
    mn  = $urandom;
    bpu = $urandom;
    nb  = $urandom_range(1, 64);
    nc  = $urandom_range(1, 4);
    case ($urandom_range(0, 5))
      0: begin
        mn  = (32'($urandom_range(0, 200)) - 32'd100) << 16;
        bpu = 32'd65536;
      end
      1: bpu = $urandom_range(65536, 65536 * 16);
      2: bpu = $urandom_range(1, 65536);
      3: begin
        nb = $urandom;
        nc = $urandom;
      end
      4: begin
        mn  = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        bpu = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        case ($urandom_range(0, 3))
          0:       nb = 0;
          1:       nb = 1;
          2:       nb = 64;
          default: nb = 127;
        endcase
        nc = $urandom_range(0, 1) ? 0 : 7;
      end
      default: begin
        nb = 64;
        nc = 4;
      end
    endcase
    if ($urandom_range(0, 3) == 0) nb[31:NbW] = (32-NbW)'($urandom);
    if ($urandom_range(0, 3) == 0) nc[31:NcW] = (32-NcW)'($urandom);
    write_regs(mn, bpu, nb, nc);
  endtask

  initial begin : stimulus
    int unsigned idle_pct;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    kind_i         = KIND_NONE;
    component_i    = '0;
    sample_value_i = '0;
    weight_i       = '0;
    read_bin_i     = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_MIN_VALUE;
    cfg_data_i     = '0;
    cur_min        = MinValueRst;
    cur_bpu        = BinsPerUnitRst;
    nb_eff         = 32'(BinsInUseRst);
    nc_eff         = 32'(CompsInUseRst);
    settings       = 1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, under the reset settings (minimum 0, unit bins, 50 bins,
    // one component).
    send_item(KIND_ADD, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);   // bin 0, max weight
    send_item(KIND_ADD, 2'd0, 32'h0031_FFFF, 32'h0000_0001, 6'd63);  // top bin in use
    send_item(KIND_ADD, 2'd0, 32'h0032_0000, 32'h0000_0100, 6'd0);   // one past: dropped
    send_item(KIND_ADD, 2'd0, 32'hFFFF_FFFF, 32'h0000_0010, 6'd0);   // just below min: bin 0
    send_item(KIND_ADD, 2'd0, 32'hFFFF_0000, 32'h0000_1000, 6'd0);   // a full bin below: dropped
    send_item(KIND_ADD, 2'd1, 32'h0001_0000, 32'h0000_0005, 6'd0);   // component not in use
    send_item(KIND_ADD, 2'd0, 32'h7FFF_FFFF, 32'h0000_0007, 6'd0);   // largest value
    send_item(KIND_ADD, 2'd0, 32'h8000_0000, 32'h0000_0009, 6'd0);   // smallest value
    send_item(KIND_ADD, 2'd0, 32'h0001_8000, 32'h0000_0000, 6'd0);   // zero weight
    send_item(KIND_READ, 2'd0, 32'h0, 32'h0, 6'd0);
    send_item(KIND_READ, 2'd0, 32'h0, 32'h0, 6'd49);
    send_item(KIND_READ, 2'd0, 32'h0, 32'h0, 6'd50);                 // bin not in use
    send_item(KIND_READ, 2'd1, 32'h0, 32'h0, 6'd0);                  // component not in use
    send_item(KIND_READ, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_item(KIND_NONE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63); // unused kind
    send_item(KIND_READ, 2'd0, 32'h0, 32'h0, 6'd0);
    send_item(KIND_CLEAR, 2'd0, 32'h0, 32'h0, 6'd0);
    send_item(KIND_READ, 2'd0, 32'h0, 32'h0, 6'd0);

    // Extreme minimum and finest scale: the full span lands far out of range,
    // while a few ulps above the minimum hit the low bins.
    write_regs(32'h8000_0000, 32'hFFFF_FFFF, 32'd64, 32'd4);
    send_item(KIND_ADD, 2'd3, 32'h8000_003F, 32'h0000_0005, 6'd0);
    send_item(KIND_ADD, 2'd3, 32'h7FFF_FFFF, 32'h0000_0007, 6'd0);
    send_item(KIND_ADD, 2'd0, 32'h8000_0000, 32'h0000_0003, 6'd0);
    send_item(KIND_READ, 2'd3, 32'h0, 32'h0, 6'd62);
    send_item(KIND_READ, 2'd0, 32'h0, 32'h0, 6'd0);

    // Zero scale puts everything in bin 0; counts above the maxima clamp.
    write_regs(32'h7FFF_FFFF, 32'h0, 32'd127, 32'd7);
    send_item(KIND_ADD, 2'd2, 32'h8000_0000, 32'h0000_0009, 6'd0);
    send_item(KIND_READ, 2'd2, 32'h0, 32'h0, 6'd0);
    send_item(KIND_READ, 2'd3, 32'h0, 32'h0, 6'd62);

    // No bins and no components in use: adds dropped, reads answer zero.
    write_regs(32'h0, 32'd65536, 32'd0, 32'd0);
    send_item(KIND_ADD, 2'd0, 32'h0000_8000, 32'h0000_0011, 6'd0);
    send_item(KIND_READ, 2'd0, 32'h0, 32'h0, 6'd0);

    // Bins above a lowered count stay stored but read as zero until the
    // count is raised again.
    write_regs(32'h0, 32'd65536, 32'd64, 32'd4);
    send_item(KIND_ADD, 2'd1, 32'h003C_4000, 32'h0000_0003, 6'd0);
    write_regs(32'h0, 32'd65536, 32'd50, 32'd4);
    send_item(KIND_READ, 2'd1, 32'h0, 32'h0, 6'd60);
    write_regs(32'h0, 32'd65536, 32'd64, 32'd4);
    send_item(KIND_READ, 2'd1, 32'h0, 32'h0, 6'd60);
    send_item(KIND_READ, 2'd2, 32'h0, 32'h0, 6'd0);
    send_item(KIND_CLEAR, 2'd0, 32'h0, 32'h0, 6'd0);

    // Random phases, each under a fresh setting. Gaps come in bursts at a
    // rate chosen per phase (sometimes none); the last phase runs flat out.
    for (int p = 0; p < Phases; p++) begin
      random_setting();
      idle_pct = (p == Phases - 1) ? 0 : $urandom_range(0, 30);
      for (int n = 0; n < PhaseLen; n++) begin
        if ($urandom_range(1, 100) <= idle_pct) hold_off($urandom_range(1, 16));
        if (p == 2 && n == PhaseLen / 2) drain();
        send_random_item();
      end
    end

    drain();
    $display("Summary: %0d items sent over %0d register settings, %0d bin reads compared.",
             items_seen, settings, reads_checked);
    $display("Covered field extremes, dropped samples, hidden bins, clears and random mixes.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### weighted_histogram_accumulator_top.f
rtl/core/wha_pkg.sv
rtl/core/weighted_histogram_accumulator_top.sv
tb/sv/histogram_checker.sv
tb/sv/testbench.sv
